// ===== rtl/aolpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aolpq_pkg: shared types for the A-star open-list priority queue
// Entry layout, channel items, operation and status codes, the cell control
// group and the priority key function.
// ----------------------------------------------------------------------------
package aolpq_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 20;
  localparam int WEIGHT_W = 4;

  typedef logic [CAPACITY-1:0] cell_vec_t;
  typedef logic [CNT_W-1:0]    count_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_DELETE = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_APPLY = 1'b1
  } state_e;

  typedef struct packed {
    logic [5:0] heading;
    logic [9:0] y;
    logic [9:0] x;
  } place_t;

  typedef struct packed {
    logic [7:0]  prim;
    place_t      place;
    logic [15:0] h;
    logic [15:0] g;
  } entry_t;

  typedef struct packed {
    op_e         kind;
    logic [15:0] cost_so_far;
    logic [15:0] heuristic;
    logic [9:0]  x_coord;
    logic [9:0]  y_coord;
    logic [5:0]  heading;
    logic [7:0]  primitive_id;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic        found;
    logic [15:0] out_cost;
    logic [15:0] out_heuristic;
    logic [9:0]  out_x;
    logic [9:0]  out_y;
    logic [5:0]  out_heading;
    logic [7:0]  out_primitive;
    logic [6:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic load_new;
    logic from_left;
    logic from_right;
  } cell_ctl_t;

  // Priority key g + weight * h; the widest value fits in KEY_W bits.
  function automatic key_t key_of(logic [15:0] g, logic [15:0] h, weight_t w);
    key_t k;
    k = key_t'(g) + key_t'(w) * key_t'(h);
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/aolpq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aolpq_cell: one slot of the sorted open list
// Holds one entry, compares its own key and place against the item on offer,
// and loads the new entry or a neighbour's entry when told to.
// ----------------------------------------------------------------------------
module aolpq_cell (
  input  wire                       clk,
  input  wire aolpq_pkg::weight_t   weight,
  input  wire aolpq_pkg::key_t      new_key,
  input  wire aolpq_pkg::place_t    probe,
  input  wire aolpq_pkg::cell_ctl_t ctl,
  input  wire aolpq_pkg::entry_t    new_entry,
  input  wire aolpq_pkg::entry_t    left_entry,
  input  wire aolpq_pkg::entry_t    right_entry,
  output aolpq_pkg::entry_t         entry,
  output logic                      ge,
  output logic                      hit
);

  aolpq_pkg::key_t own_key;

  assign own_key = aolpq_pkg::key_of(entry.g, entry.h, weight);
  assign ge      = (own_key >= new_key);
  assign hit     = (entry.place == probe);

  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      entry <= new_entry;
    end else if (ctl.from_left) begin
      entry <= left_entry;
    end else if (ctl.from_right) begin
      entry <= right_entry;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/astar_open_list_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// astar_open_list_priority_queue: sorted open list for weighted A-star
// A row of cells kept in ascending order of g + weight * h, with insert,
// pop-minimum, delete-by-place and membership query operations.
// ----------------------------------------------------------------------------
// When an item is accepted, every cell compares its own key and place
// against the item in parallel and the results are registered; in the apply
// step the first qualifying cell is picked, the row shifts by one place
// towards the right (insert) or the left (pop, delete) and the result item
// is written to the output register. The time does not depend on how many
// entries are held. A new item is accepted
// once the previous one has been applied; the apply step waits while an
// earlier result still sits unclaimed in the output register. The heuristic
// weight is read live by every cell, so it should only be written while the
// queue is idle; entries already held keep their order after a change.
// An insert goes ahead of all entries with an equal key, an insert into a
// full queue is dropped with status full, and delete and query act on the
// first matching entry in queue order.
module astar_open_list_priority_queue (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire aolpq_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire                       out_ready,
  output aolpq_pkg::out_item_t      out_data,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire aolpq_pkg::weight_t   cfg_data
);

  localparam int N = aolpq_pkg::CAPACITY;

  // Control state.
  aolpq_pkg::state_e  state;
  aolpq_pkg::state_e  state_next;
  aolpq_pkg::count_t  count;
  aolpq_pkg::count_t  count_next;
  aolpq_pkg::weight_t weight;

  // Item under way and the registered outcome of the parallel compare.
  aolpq_pkg::in_item_t  item;
  aolpq_pkg::cell_vec_t ge_q;
  aolpq_pkg::cell_vec_t hit_q;

  // Row of cells.
  aolpq_pkg::entry_t    cell_entry [N];
  aolpq_pkg::cell_ctl_t cell_ctl   [N];
  aolpq_pkg::cell_vec_t ge_vec;
  aolpq_pkg::cell_vec_t hit_vec;

  aolpq_pkg::key_t   new_key;
  aolpq_pkg::place_t probe;
  aolpq_pkg::entry_t new_entry;

  logic accept;
  logic apply_en;

  // Selection signals of the apply step.
  aolpq_pkg::cell_vec_t valid_vec;
  aolpq_pkg::cell_vec_t ins_cand;
  aolpq_pkg::cell_vec_t ins_first;
  aolpq_pkg::cell_vec_t ins_tail;
  aolpq_pkg::cell_vec_t hit_eff;
  aolpq_pkg::cell_vec_t hit_first;
  aolpq_pkg::cell_vec_t rem_first;
  aolpq_pkg::cell_vec_t rem_tail;
  aolpq_pkg::entry_t    sel_entry;
  logic                 full;
  logic                 empty;
  logic                 any_hit;
  logic                 ins_go;
  logic                 rem_go;
  aolpq_pkg::out_item_t result;

  // The item on offer at the input: its key and its place.
  assign new_key = aolpq_pkg::key_of(in_data.cost_so_far, in_data.heuristic, weight);
  assign probe   = '{heading: in_data.heading, y: in_data.y_coord, x: in_data.x_coord};

  // The entry to be inserted comes from the held item.
  assign new_entry = '{
    prim:  item.primitive_id,
    place: '{heading: item.heading, y: item.y_coord, x: item.x_coord},
    h:     item.heuristic,
    g:     item.cost_so_far
  };

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // The cells: each looks left for inserts and right for removals. The ends
  // of the row see their own entry, so taking it leaves that cell unchanged.
  for (genvar i = 0; i < N; i++) begin : g_cell
    aolpq_pkg::entry_t left_entry;
    aolpq_pkg::entry_t right_entry;

    if (i == 0) begin : g_first
      assign left_entry = cell_entry[i];
    end else begin : g_mid_l
      assign left_entry = cell_entry[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_mid_r
      assign right_entry = cell_entry[i+1];
    end

    aolpq_cell u_cell (
      .clk         (clk),
      .weight      (weight),
      .new_key     (new_key),
      .probe       (probe),
      .ctl         (cell_ctl[i]),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .ge          (ge_vec[i]),
      .hit         (hit_vec[i])
    );
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      aolpq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = aolpq_pkg::S_APPLY;
        end
      end
      aolpq_pkg::S_APPLY: begin
        if (!out_valid || out_ready) begin
          state_next = aolpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = aolpq_pkg::S_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    apply_en = 1'b0;
    case (state)
      aolpq_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      aolpq_pkg::S_APPLY: begin
        apply_en = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Apply step: pick the first qualifying cell and work out the shift.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid_vec[i] = (aolpq_pkg::count_t'(i) < count);
    end

    full    = (count == aolpq_pkg::count_t'(N));
    empty   = (count == '0);

    // Unused cells count as larger than any key, so an insert behind all
    // held entries lands in the first free cell.
    ins_cand  = ge_q | ~valid_vec;
    ins_first = ins_cand & (~ins_cand + aolpq_pkg::cell_vec_t'(1));
    ins_tail  = ~(ins_first - aolpq_pkg::cell_vec_t'(1));

    hit_eff   = hit_q & valid_vec;
    any_hit   = (hit_eff != '0);
    hit_first = hit_eff & (~hit_eff + aolpq_pkg::cell_vec_t'(1));

    rem_first = (item.kind == aolpq_pkg::OP_POP) ? aolpq_pkg::cell_vec_t'(1) : hit_first;
    rem_tail  = ~(rem_first - aolpq_pkg::cell_vec_t'(1));

    sel_entry = '0;
    for (int i = 0; i < N; i++) begin
      if (rem_first[i]) begin
        sel_entry = sel_entry | cell_entry[i];
      end
    end

    ins_go     = 1'b0;
    rem_go     = 1'b0;
    count_next = count;
    result     = '0;

    case (item.kind)
      aolpq_pkg::OP_INSERT: begin
        if (full) begin
          result.status = aolpq_pkg::STAT_FULL;
        end else begin
          ins_go        = 1'b1;
          count_next    = count + aolpq_pkg::count_t'(1);
          result.status = aolpq_pkg::STAT_OK;
        end
      end
      aolpq_pkg::OP_POP: begin
        if (empty) begin
          result.status = aolpq_pkg::STAT_EMPTY;
        end else begin
          rem_go        = 1'b1;
          count_next    = count - aolpq_pkg::count_t'(1);
          result.status = aolpq_pkg::STAT_OK;
          result.found  = 1'b1;
        end
      end
      aolpq_pkg::OP_DELETE: begin
        if (!any_hit) begin
          result.status = aolpq_pkg::STAT_NOT_FOUND;
        end else begin
          rem_go        = 1'b1;
          count_next    = count - aolpq_pkg::count_t'(1);
          result.status = aolpq_pkg::STAT_OK;
        end
      end
      aolpq_pkg::OP_QUERY: begin
        if (!any_hit) begin
          result.status = aolpq_pkg::STAT_NOT_FOUND;
        end else begin
          result.status = aolpq_pkg::STAT_OK;
          result.found  = 1'b1;
        end
      end
      default: begin
        result.status = aolpq_pkg::STAT_NOT_FOUND;
      end
    endcase

    if (result.found) begin
      result.out_cost      = sel_entry.g;
      result.out_heuristic = sel_entry.h;
      result.out_x         = sel_entry.place.x;
      result.out_y         = sel_entry.place.y;
      result.out_heading   = sel_entry.place.heading;
      result.out_primitive = sel_entry.prim;
    end
    result.occupancy = 7'(count_next);

    for (int i = 0; i < N; i++) begin
      cell_ctl[i].load_new   = apply_en && ins_go && ins_first[i];
      cell_ctl[i].from_left  = apply_en && ins_go && ins_tail[i] && !ins_first[i];
      cell_ctl[i].from_right = apply_en && rem_go && rem_tail[i];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= aolpq_pkg::S_IDLE;
      count     <= '0;
      weight    <= aolpq_pkg::weight_t'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        weight <= cfg_data;
      end
      if (apply_en) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item and compare results, captured when the item is accepted; the
  // result item is captured in the apply step.
  always_ff @(posedge clk) begin
    if (accept) begin
      item  <= in_data;
      ge_q  <= ge_vec;
      hit_q <= hit_vec;
    end
    if (apply_en) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire
